// ===== src/cartridge_bank_mapper_core_assert.svh =====
// Assertion macros for the cartridge bank mapper checks.
// Both expect clk_i and rst_ni in scope.
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define CBM_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("cbm check failed");

// Antecedent at one edge implies consequent at the next.
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbm check failed");

`endif

// ===== src/cbm_pkg.sv =====
package cbm_pkg;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned MAX_ROM_BANKS  = 512;

  localparam int unsigned ROM_BANK_SHIFT = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_BANK_SHIFT = $clog2(RAM_BANK_BYTES);

  // remainder unit: 10-bit operands, two bits per step
  localparam int unsigned DIV_W     = 10;
  localparam int unsigned REM_STEPS = DIV_W / 2;
  localparam int unsigned STEP_W    = $clog2(REM_STEPS + 1);

  localparam logic [3:0] RAM_ENABLE_CODE = 4'hA;
  localparam logic [7:0] OPEN_BUS        = 8'hFF;
  localparam logic [3:0] RTC_FIRST_SEL   = 4'h8;
  localparam logic [3:0] RTC_LAST_SEL    = 4'hC;
  localparam logic [7:0] LATCH_ARM       = 8'h00;
  localparam logic [7:0] LATCH_FIRE      = 8'h01;

  typedef enum logic [2:0] {
    CFG_MAPPER_KIND    = 3'd0,
    CFG_ROM_BYTE_COUNT = 3'd1,
    CFG_RAM_BYTE_COUNT = 3'd2,
    CFG_RAM_BANK_COUNT = 3'd3,
    CFG_RTC_PRESENT    = 3'd4
  } cfg_index_e;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_MBC1 = 3'd1,
    KIND_MBC2 = 3'd2,
    KIND_MBC3 = 3'd3,
    KIND_MBC5 = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_ROM_READ  = 3'd1,
    TGT_RAM_READ  = 3'd2,
    TGT_RAM_WRITE = 3'd3,
    TGT_DATA      = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_done;
  } ctrl_sts_t;

  function automatic logic enable_code(input logic [7:0] v);
    return v[3:0] == RAM_ENABLE_CODE;
  endfunction

endpackage

// ===== src/cbm_rem.sv =====
module cbm_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cbm_pkg::DIV_W-1:0]     dividend_i,
  input  logic [cbm_pkg::DIV_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [cbm_pkg::DIV_W-1:0]     remainder_o
);

  logic [cbm_pkg::DIV_W-1:0]  quot_q, quot_d;
  logic [cbm_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [cbm_pkg::DIV_W-1:0]  div_q, div_d;
  logic [cbm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [cbm_pkg::DIV_W:0]    t1, t2;
  logic [cbm_pkg::DIV_W-1:0]  r1;

  // restoring division, two quotient bits per cycle
  always_comb begin
    t1 = {rem_q, quot_q[cbm_pkg::DIV_W-1]};
    if (t1 >= {1'b0, div_q}) begin
      t1 = t1 - {1'b0, div_q};
    end
    r1 = t1[cbm_pkg::DIV_W-1:0];
    t2 = {r1, quot_q[cbm_pkg::DIV_W-2]};
    if (t2 >= {1'b0, div_q}) begin
      t2 = t2 - {1'b0, div_q};
    end
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = cbm_pkg::STEP_W'(cbm_pkg::REM_STEPS);
    end else if (cnt_q != '0) begin
      quot_d = {quot_q[cbm_pkg::DIV_W-3:0], 2'b00};
      rem_d  = t2[cbm_pkg::DIV_W-1:0];
      cnt_d  = cnt_q - cbm_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o      = cnt_q == '0;
  assign remainder_o = rem_q;

endmodule

// ===== src/cbm_datapath.sv =====
module cbm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cbm_pkg::ctrl_cmd_t    cmd_i,
  output cbm_pkg::ctrl_sts_t    sts_o,
  input  logic                  cfg_valid_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i,
  input  logic                  func_i,
  input  logic [15:0]           address_i,
  input  logic [7:0]            write_data_i,
  output logic [2:0]            target_o,
  output logic [22:0]           mapped_address_o,
  output logic [7:0]            read_data_o,
  output logic [7:0]            ram_write_data_o,
  output logic                  nibble_ram_o
);

  // configuration
  logic [2:0]  mapper_kind_q;
  logic [23:0] rom_byte_count_q;
  logic [17:0] ram_byte_count_q;
  logic [4:0]  ram_bank_count_q;
  logic        rtc_present_q;

  // captured access
  logic        func_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;

  // mapper state
  logic [8:0]  rom_bank_q, rom_bank_d;
  logic [3:0]  ram_bank_q, ram_bank_d;
  logic        ram_en_q, ram_en_d;
  logic        mode_q, mode_d;
  logic        armed_q, armed_d;
  logic [7:0]  rtc_live_q [5];
  logic [7:0]  rtc_live_d [5];
  logic [7:0]  rtc_held_q [5];
  logic [7:0]  rtc_held_d [5];

  // result registers
  logic [2:0]  target_q, target_d;
  logic [22:0] maddr_q, maddr_d;
  logic [7:0]  rdata_q, rdata_d;
  logic [7:0]  rwdata_q, rwdata_d;
  logic        nib_q, nib_d;

  cbm_pkg::kind_e              kind;
  logic [8:0]                  upper_pre;
  logic [9:0]                  bank_cnt_raw;
  logic [9:0]                  bank_cnt;
  logic [cbm_pkg::DIV_W-1:0]   rem_dividend;
  logic [cbm_pkg::DIV_W-1:0]   rem_divisor;
  logic [cbm_pkg::DIV_W-1:0]   rem_result;
  logic                        rem_done;
  logic                        in_rom;
  logic                        in_ram;
  logic [22:0]                 rom_addr;
  logic                        rom_ok;
  logic [16:0]                 ram_off;
  logic                        ram_ok;
  logic                        rtc_sel;
  logic [2:0]                  rtc_idx;
  logic [4:0]                  b5;
  logic [6:0]                  b7;
  logic [3:0]                  b4;

  assign kind = (mapper_kind_q > 3'(cbm_pkg::KIND_MBC5)) ? cbm_pkg::KIND_NONE
                                                         : cbm_pkg::kind_e'(mapper_kind_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_kind_q    <= 3'(cbm_pkg::KIND_NONE);
      rom_byte_count_q <= 24'd32768;
      ram_byte_count_q <= '0;
      ram_bank_count_q <= '0;
      rtc_present_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cbm_pkg::CFG_MAPPER_KIND:    mapper_kind_q    <= cfg_data_i[2:0];
        cbm_pkg::CFG_ROM_BYTE_COUNT: rom_byte_count_q <= cfg_data_i;
        cbm_pkg::CFG_RAM_BYTE_COUNT: ram_byte_count_q <= cfg_data_i[17:0];
        cbm_pkg::CFG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_data_i[4:0];
        cbm_pkg::CFG_RTC_PRESENT:    rtc_present_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
  end

  // upper ROM bank before reduction by the bank count
  always_comb begin
    upper_pre = 9'd1;
    unique case (kind)
      cbm_pkg::KIND_MBC5: upper_pre = rom_bank_q;
      cbm_pkg::KIND_MBC1: begin
        upper_pre = mode_q ? {4'b0, rom_bank_q[4:0]} : {2'b0, rom_bank_q[6:0]};
        if (upper_pre[4:0] == 5'd0) begin
          upper_pre = upper_pre + 9'd1;
        end
      end
      cbm_pkg::KIND_MBC2: begin
        upper_pre = {5'b0, rom_bank_q[3:0]};
        if (upper_pre == 9'd0) begin
          upper_pre = 9'd1;
        end
      end
      cbm_pkg::KIND_MBC3: begin
        upper_pre = {2'b0, rom_bank_q[6:0]};
        if (upper_pre == 9'd0) begin
          upper_pre = 9'd1;
        end
      end
      default: upper_pre = 9'd1;
    endcase
  end

  assign bank_cnt_raw = rom_byte_count_q[23:cbm_pkg::ROM_BANK_SHIFT];

  always_comb begin
    bank_cnt = bank_cnt_raw;
    if (bank_cnt_raw < 10'd2) begin
      bank_cnt = 10'd2;
    end else if (bank_cnt_raw > 10'(cbm_pkg::MAX_ROM_BANKS)) begin
      bank_cnt = 10'(cbm_pkg::MAX_ROM_BANKS);
    end
  end

  // a zero divisor leaves the dividend as the remainder
  assign rem_dividend = addr_q[15] ? {6'b0, ram_bank_q} : {1'b0, upper_pre};
  assign rem_divisor  = addr_q[15] ? {5'b0, ram_bank_count_q} : bank_cnt;

  cbm_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.start),
    .dividend_i  (rem_dividend),
    .divisor_i   (rem_divisor),
    .done_o      (rem_done),
    .remainder_o (rem_result)
  );

  assign sts_o.rem_done = rem_done;

  assign in_rom  = !addr_q[15];
  assign in_ram  = addr_q[15:13] == 3'b101;
  assign rtc_sel = (kind == cbm_pkg::KIND_MBC3) && (ram_bank_q >= cbm_pkg::RTC_FIRST_SEL)
                   && (ram_bank_q <= cbm_pkg::RTC_LAST_SEL);
  assign rtc_idx = ram_bank_q[2:0];

  assign rom_addr = addr_q[14] ? {rem_result[8:0], addr_q[13:0]} : {9'b0, addr_q[13:0]};
  assign rom_ok   = {1'b0, rom_addr} < rom_byte_count_q;

  always_comb begin
    if (kind == cbm_pkg::KIND_MBC2) begin
      ram_off = {8'b0, addr_q[8:0]};
    end else if (kind == cbm_pkg::KIND_MBC1 && !mode_q) begin
      ram_off = {4'b0, addr_q[12:0]};
    end else begin
      ram_off = {rem_result[3:0], addr_q[cbm_pkg::RAM_BANK_SHIFT-1:0]};
    end
  end

  assign ram_ok = {1'b0, ram_off} < ram_byte_count_q;

  always_comb begin
    target_d = cbm_pkg::TGT_NONE;
    maddr_d  = '0;
    rdata_d  = '0;
    rwdata_d = '0;
    nib_d    = 1'b0;
    if (in_rom) begin
      if (!func_q) begin
        if (rom_ok) begin
          target_d = cbm_pkg::TGT_ROM_READ;
          maddr_d  = rom_addr;
        end else begin
          target_d = cbm_pkg::TGT_DATA;
          rdata_d  = cbm_pkg::OPEN_BUS;
        end
      end
    end else if (in_ram) begin
      if (func_q) begin
        if (ram_en_q && !rtc_sel && ram_ok) begin
          target_d = cbm_pkg::TGT_RAM_WRITE;
          maddr_d  = {6'b0, ram_off};
          rwdata_d = (kind == cbm_pkg::KIND_MBC2) ? {4'b0, wdata_q[3:0]} : wdata_q;
        end
      end else if (!ram_en_q) begin
        target_d = cbm_pkg::TGT_DATA;
        rdata_d  = cbm_pkg::OPEN_BUS;
      end else if (rtc_sel) begin
        target_d = cbm_pkg::TGT_DATA;
        rdata_d  = rtc_held_q[rtc_idx];
      end else if (ram_ok) begin
        target_d = cbm_pkg::TGT_RAM_READ;
        maddr_d  = {6'b0, ram_off};
        nib_d    = kind == cbm_pkg::KIND_MBC2;
      end else begin
        target_d = cbm_pkg::TGT_DATA;
        rdata_d  = cbm_pkg::OPEN_BUS;
      end
    end
  end

  // mapper register writes and RTC access
  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    ram_en_d   = ram_en_q;
    mode_d     = mode_q;
    armed_d    = armed_q;
    rtc_live_d = rtc_live_q;
    rtc_held_d = rtc_held_q;
    b5 = (wdata_q[4:0] == 5'd0) ? 5'd1 : wdata_q[4:0];
    b7 = (wdata_q[6:0] == 7'd0) ? 7'd1 : wdata_q[6:0];
    b4 = (wdata_q[3:0] == 4'd0) ? 4'd1 : wdata_q[3:0];
    if (cmd_i.commit && func_q) begin
      if (in_ram && ram_en_q && rtc_sel) begin
        rtc_live_d[rtc_idx] = wdata_q;
      end else if (in_rom) begin
        unique case (kind)
          cbm_pkg::KIND_MBC1: begin
            unique case (addr_q[14:13])
              2'b00: ram_en_d = cbm_pkg::enable_code(wdata_q);
              2'b01: rom_bank_d = {2'b0, rom_bank_q[6:5], b5};
              2'b10: begin
                if (mode_q) begin
                  ram_bank_d = {2'b0, wdata_q[1:0]};
                end else begin
                  rom_bank_d = {2'b0, wdata_q[1:0], rom_bank_q[4:0]};
                end
              end
              default: begin
                mode_d = wdata_q[0];
                if (!wdata_q[0]) begin
                  ram_bank_d = '0;
                end
              end
            endcase
          end
          cbm_pkg::KIND_MBC2: begin
            if (!addr_q[14]) begin
              if (addr_q[8]) begin
                rom_bank_d = {5'b0, b4};
              end else begin
                ram_en_d = cbm_pkg::enable_code(wdata_q);
              end
            end
          end
          cbm_pkg::KIND_MBC3: begin
            unique case (addr_q[14:13])
              2'b00: ram_en_d = cbm_pkg::enable_code(wdata_q);
              2'b01: rom_bank_d = {2'b0, b7};
              2'b10: begin
                if (wdata_q <= 8'h03 || (wdata_q >= {4'b0, cbm_pkg::RTC_FIRST_SEL}
                    && wdata_q <= {4'b0, cbm_pkg::RTC_LAST_SEL})) begin
                  ram_bank_d = wdata_q[3:0];
                end
              end
              default: begin
                if (wdata_q == cbm_pkg::LATCH_ARM) begin
                  armed_d = 1'b1;
                end else if (wdata_q == cbm_pkg::LATCH_FIRE && armed_q) begin
                  armed_d = 1'b0;
                  if (rtc_present_q) begin
                    rtc_held_d = rtc_live_q;
                  end
                end
              end
            endcase
          end
          cbm_pkg::KIND_MBC5: begin
            unique case (addr_q[14:13])
              2'b00: ram_en_d = cbm_pkg::enable_code(wdata_q);
              2'b01: begin
                if (!addr_q[12]) begin
                  rom_bank_d = {rom_bank_q[8], wdata_q};
                end else begin
                  rom_bank_d = {wdata_q[0], rom_bank_q[7:0]};
                end
              end
              2'b10: ram_bank_d = wdata_q[3:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= 9'd1;
      ram_bank_q <= '0;
      ram_en_q   <= 1'b0;
      mode_q     <= 1'b0;
      armed_q    <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        rtc_live_q[i] <= '0;
        rtc_held_q[i] <= '0;
      end
    end else begin
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      ram_en_q   <= ram_en_d;
      mode_q     <= mode_d;
      armed_q    <= armed_d;
      rtc_live_q <= rtc_live_d;
      rtc_held_q <= rtc_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      target_q <= target_d;
      maddr_q  <= maddr_d;
      rdata_q  <= rdata_d;
      rwdata_q <= rwdata_d;
      nib_q    <= nib_d;
    end
  end

  assign target_o         = target_q;
  assign mapped_address_o = maddr_q;
  assign read_data_o      = rdata_q;
  assign ram_write_data_o = rwdata_q;
  assign nibble_ram_o     = nib_q;

endmodule

// ===== src/cbm_ctrl.sv =====
module cbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbm_pkg::ctrl_cmd_t cmd_o,
  input  cbm_pkg::ctrl_sts_t sts_i
);

  cbm_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      cbm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cbm_pkg::ST_START;
        end
      end
      cbm_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = cbm_pkg::ST_DIV;
      end
      cbm_pkg::ST_DIV: begin
        // result goes out once the output register is free
        if (sts_i.rem_done && (!out_valid_q || !out_stall_i)) begin
          cmd_o.commit = 1'b1;
          state_d      = cbm_pkg::ST_IDLE;
        end
      end
      default: state_d = cbm_pkg::ST_IDLE;
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/cartridge_bank_mapper_core.sv =====
// Cartridge bank mapper: one bus access in (read/write, address, byte), one
// result out telling whether it hits ROM, cartridge RAM, or is answered directly
// (RTC byte or 0xFF open bus). Supports no mapper, MBC1, MBC2, MBC3 and MBC5.
// Each access passes through a capture, a start and a commit step, with the bank
// number reduced modulo the ROM or RAM bank count between start and commit by a
// shared remainder unit that retires two bits per cycle; no new access is taken
// until the commit. A new access is taken while the previous result still waits
// in the output register. Configuration writes are taken in any cycle
// (cfg_ready_o is always high) and must only be issued while the block is idle.
module cartridge_bank_mapper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_o,
  output logic [22:0] mapped_address_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  ram_write_data_o,
  output logic        nibble_ram_o
);

  cbm_pkg::ctrl_cmd_t cmd;
  cbm_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cbm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .target_o         (target_o),
    .mapped_address_o (mapped_address_o),
    .read_data_o      (read_data_o),
    .ram_write_data_o (ram_write_data_o),
    .nibble_ram_o     (nibble_ram_o)
  );

endmodule

// ===== src/cbm_checker.sv =====
`include "cartridge_bank_mapper_core_assert.svh"

module cbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  target_o,
  input logic [22:0] mapped_address_o,
  input logic [7:0]  read_data_o,
  input logic [7:0]  ram_write_data_o,
  input logic        nibble_ram_o
);

  // stalled result holds
  `CBM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(target_o) && $stable(mapped_address_o) && $stable(read_data_o) && $stable(ram_write_data_o) && $stable(nibble_ram_o))

  // one access at a time: busy right after an input transfer
  `CBM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `CBM_ASSERT_HOLDS(a_rdata_only_data, !out_valid_o || target_o == cbm_pkg::TGT_DATA || read_data_o == 8'h00)

  `CBM_ASSERT_HOLDS(a_side_fields, !out_valid_o || ((target_o == cbm_pkg::TGT_RAM_WRITE || ram_write_data_o == 8'h00) && (target_o == cbm_pkg::TGT_RAM_READ || !nibble_ram_o)))

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (.*);
